// File: rtl/arlm_pkg.sv
// arlm_pkg: shared types, codes and reply string tables for the at reply line matcher
// no dependencies; imported by arlm_line_match, at_reply_line_matcher_core and the testbench
`timescale 1ns / 1ps

package arlm_pkg;

  // operation codes of an input transaction
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // outcome codes of a result transaction
  localparam logic [2:0] OUT_OK      = 3'd0;
  localparam logic [2:0] OUT_ERROR   = 3'd1;
  localparam logic [2:0] OUT_BUSY    = 3'd2;
  localparam logic [2:0] OUT_READY   = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT = 3'd4;
  localparam logic [2:0] OUT_FULL    = 3'd5;

  localparam int          NUM_PATTERNS     = 4;
  localparam int          BUFFER_BYTES_DEF = 1024;
  localparam logic [31:0] TIMEOUT_RESET    = 32'd2000;
  localparam logic [7:0]  CHAR_NEWLINE     = 8'h0A;
  localparam logic [3:0]  POS_MAX          = 4'd15;

  // result of comparing one byte against the reply strings
  typedef struct packed {
    logic [NUM_PATTERNS-1:0] alive;
    logic [3:0]              position;
    logic                    newline;
    logic                    hit;
    logic [1:0]              hit_index;
  } match_t;

  // length of each reply string
  function automatic logic [3:0] pat_len(input logic [1:0] idx);
    case (idx)
      2'd0:    pat_len = 4'd4;
      2'd1:    pat_len = 4'd7;
      2'd2:    pat_len = 4'd11;
      default: pat_len = 4'd7;
    endcase
  endfunction

  // byte of a reply string at a line position, zero past the end
  function automatic logic [7:0] pat_byte(input logic [1:0] idx, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      2'd0: begin
        case (pos)
          4'd0:    c = "O";
          4'd1:    c = "K";
          4'd2:    c = 8'h0D;
          4'd3:    c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0:    c = "E";
          4'd1:    c = "R";
          4'd2:    c = "R";
          4'd3:    c = "O";
          4'd4:    c = "R";
          4'd5:    c = 8'h0D;
          4'd6:    c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0:    c = "b";
          4'd1:    c = "u";
          4'd2:    c = "s";
          4'd3:    c = "y";
          4'd4:    c = " ";
          4'd5:    c = "p";
          4'd6:    c = 8'hE2;
          4'd7:    c = 8'h80;
          4'd8:    c = 8'hA6;
          4'd9:    c = 8'h0D;
          4'd10:   c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          4'd0:    c = "r";
          4'd1:    c = "e";
          4'd2:    c = "a";
          4'd3:    c = "d";
          4'd4:    c = "y";
          4'd5:    c = 8'h0D;
          4'd6:    c = 8'h0A;
          default: c = 8'h00;
        endcase
      end
    endcase
    pat_byte = c;
  endfunction

endpackage

// File: rtl/at_reply_line_matcher_core.sv
// at_reply_line_matcher_core: top level of the at reply line matcher
// depends on arlm_pkg and arlm_line_match
`timescale 1ns / 1ps

//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------
//  input    | in        | in_valid / in_stall   | operation, rx_byte
//  result   | out       | out_valid / out_stall | outcome, bytes_seen
//  config   | in        | cfg_write_enable      | cfg_write_data
//
// one transaction per cycle unless stalled: an input register feeds a single
// combinational pass (pattern compare, counter and timeout check), which
// updates the state and loads the result register as the held transaction
// leaves the input register. rst is synchronous and returns the block to
// idle with the timeout at 2000 ticks. a stalled result holds; the input
// stage only stalls when its held transaction would produce a result while
// the result register is full and stalled.

module at_reply_line_matcher_core
  import arlm_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  outcome,
  output logic [9:0]  bytes_seen,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data
);

  // counter never goes past BUFFER_BYTES-1 while waiting
  localparam int              CNT_W    = $clog2(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_BYTES - 1);

  // input register
  logic       in_q_valid;
  logic [1:0] op_q;
  logic [7:0] byte_q;

  // block state
  logic                    waiting;
  logic [3:0]              line_position;
  logic [NUM_PATTERNS-1:0] patterns_alive;
  logic [CNT_W-1:0]        byte_counter;
  logic [31:0]             elapsed_ticks;
  logic [31:0]             timeout_ticks;

  logic                    waiting_next;
  logic [3:0]              line_position_next;
  logic [NUM_PATTERNS-1:0] patterns_alive_next;
  logic [CNT_W-1:0]        byte_counter_next;
  logic [31:0]             elapsed_ticks_next;

  logic       produce;
  logic [2:0] outcome_next;
  logic       advance;
  match_t     match;

  arlm_line_match u_match (
    .line_position  (line_position),
    .patterns_alive (patterns_alive),
    .rx_byte        (byte_q),
    .match          (match)
  );

  // one pass over the held transaction
  always_comb begin
    waiting_next        = waiting;
    line_position_next  = line_position;
    patterns_alive_next = patterns_alive;
    byte_counter_next   = byte_counter;
    elapsed_ticks_next  = elapsed_ticks;
    produce             = 1'b0;
    outcome_next        = OUT_OK;
    case (op_q)
      OP_START: begin
        // arm or re-arm, clear everything
        waiting_next        = 1'b1;
        line_position_next  = 4'd0;
        patterns_alive_next = '1;
        byte_counter_next   = '0;
        elapsed_ticks_next  = '0;
      end
      OP_TICK: begin
        if (waiting) begin
          // saturating tick count
          elapsed_ticks_next = elapsed_ticks + 32'(elapsed_ticks != '1);
          if (elapsed_ticks_next >= timeout_ticks) begin
            produce      = 1'b1;
            outcome_next = OUT_TIMEOUT;
            waiting_next = 1'b0;
          end
        end
      end
      OP_BYTE: begin
        if (waiting) begin
          byte_counter_next   = byte_counter + CNT_W'(1);
          line_position_next  = match.position;
          patterns_alive_next = match.alive;
          if (match.hit) begin
            // exact line match beats buffer full
            produce      = 1'b1;
            outcome_next = {1'b0, match.hit_index};
            waiting_next = 1'b0;
          end else begin
            if (match.newline) begin
              // unmatched line, start a fresh one
              line_position_next  = 4'd0;
              patterns_alive_next = '1;
            end
            if (byte_counter_next >= CNT_LAST) begin
              produce      = 1'b1;
              outcome_next = OUT_FULL;
              waiting_next = 1'b0;
            end
          end
        end
      end
      default: begin
        // unused code, no effect
      end
    endcase
  end

  // held transaction moves on unless its result would hit a stalled full register
  assign advance  = in_q_valid && (!produce || !out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      op_q   <= operation;
      byte_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting        <= 1'b0;
      line_position  <= 4'd0;
      patterns_alive <= '1;
      byte_counter   <= '0;
      elapsed_ticks  <= '0;
    end else if (advance) begin
      waiting        <= waiting_next;
      line_position  <= line_position_next;
      patterns_alive <= patterns_alive_next;
      byte_counter   <= byte_counter_next;
      elapsed_ticks  <= elapsed_ticks_next;
    end
  end

  // timeout register, a new value is compared on the next tick
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write_enable) begin
      timeout_ticks <= cfg_write_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && produce) begin
      outcome    <= outcome_next;
      bytes_seen <= 10'(byte_counter_next);
    end
  end

endmodule

// File: rtl/arlm_line_match.sv
// arlm_line_match: compares one received byte against the four reply strings
// depends on arlm_pkg for the string tables and match_t
`timescale 1ns / 1ps

module arlm_line_match
  import arlm_pkg::*;
(
  input  logic [3:0]              line_position,
  input  logic [NUM_PATTERNS-1:0] patterns_alive,
  input  logic [7:0]              rx_byte,
  output match_t                  match
);

  logic [NUM_PATTERNS-1:0] alive_next;
  logic [3:0]              pos_next;
  logic                    hit;
  logic [1:0]              hit_index;

  always_comb begin
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      alive_next[i] = patterns_alive[i]
                      && (line_position < pat_len(2'(i)))
                      && (pat_byte(2'(i), line_position) == rx_byte);
    end
  end

  assign pos_next = (line_position == POS_MAX) ? line_position : line_position + 4'd1;

  // lowest index wins
  always_comb begin
    hit       = 1'b0;
    hit_index = 2'd0;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (alive_next[i] && (pos_next == pat_len(2'(i)))) begin
        hit       = 1'b1;
        hit_index = 2'(i);
      end
    end
  end

  assign match.alive     = alive_next;
  assign match.position  = pos_next;
  assign match.newline   = (rx_byte == CHAR_NEWLINE);
  assign match.hit       = hit && (rx_byte == CHAR_NEWLINE);
  assign match.hit_index = hit_index;

endmodule

// File: tb/at_reply_line_matcher_core_tb.sv
// at_reply_line_matcher_core_tb: self-checking testbench for the at reply line matcher
// depends on arlm_pkg and at_reply_line_matcher_core; predicts every reply and checks it
`timescale 1ns / 1ps

module at_reply_line_matcher_core_tb
  import arlm_pkg::*;
();

  // operation code the block leaves unused; it must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // reply strings, right-justified, first character in the highest byte of the string
  localparam logic [87:0] OK_LINE    = 88'({"OK", 8'h0D, 8'h0A});
  localparam logic [87:0] ERROR_LINE = 88'({"ERROR", 8'h0D, 8'h0A});
  localparam logic [87:0] BUSY_LINE  = {"busy p", 8'hE2, 8'h80, 8'hA6, 8'h0D, 8'h0A};
  localparam logic [87:0] READY_LINE = 88'({"ready", 8'h0D, 8'h0A});

  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int DRAIN_TAIL  = 4;      // settling margin after the drain
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 25;

  // one input transaction and one result transaction
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } at_xact_t;

  typedef struct packed {
    logic [2:0] code;
    logic [9:0] count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_START;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  outcome;
  logic [9:0]  bytes_seen;
  logic        cfg_write_enable = 1'b0;
  logic [31:0] cfg_write_data = 32'h0;

  at_reply_line_matcher_core #(
    .BUFFER_BYTES(BUFFER_BYTES_DEF)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .outcome          (outcome),
    .bytes_seen       (bytes_seen),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always #6 clk = ~clk;

  // transactions waiting to be offered, and replies the matcher still owes
  at_xact_t tx_items[$];
  reply_t   replies_due[$];

  // shadow copy of the matcher state and its timeout register
  bit          armed = 1'b0;
  logic [3:0]  line_pos = 4'd0;
  logic [3:0]  alive = 4'hF;
  int          rx_count = 0;
  logic [31:0] ticks = 32'd0;
  logic [31:0] timeout_limit = TIMEOUT_RESET;

  // knobs set by the sequencer, read by driver and receiver
  int send_gap_max = 8;
  int recv_stall_max = 8;
  int hold_requests = 0;
  int hold_served = 0;
  bit tick_mix = 1'b0;

  int       failures = 0;
  int       staged = 0;
  int       send_wait = 0;
  int       recv_wait = 0;
  int       cycles = 0;
  at_xact_t head_xact;
  reply_t   due;

  function automatic int reply_len(input int k);
    case (k)
      0:       return 4;
      1:       return 7;
      2:       return 11;
      default: return 7;
    endcase
  endfunction

  function automatic logic [7:0] reply_byte(input int k, input int pos);
    logic [87:0] text;
    case (k)
      0:       text = OK_LINE;
      1:       text = ERROR_LINE;
      2:       text = BUSY_LINE;
      default: text = READY_LINE;
    endcase
    return text[8*(reply_len(k)-1-pos) +: 8];
  endfunction

  // any outcome ends the wait and carries the byte count so far
  task automatic end_wait(input logic [2:0] code);
    reply_t r;
    r.code = code;
    r.count = rx_count[9:0];
    replies_due.push_back(r);
    armed = 1'b0;
  endtask

  // advance the line matcher by one accepted transaction
  task automatic advance_matcher(input logic [1:0] op, input logic [7:0] data);
    int k;
    bit hit;
    hit = 1'b0;
    case (op)
      OP_START: begin
        armed = 1'b1;
        line_pos = 4'd0;
        alive = 4'hF;
        rx_count = 0;
        ticks = 32'd0;
      end
      OP_TICK: begin
        if (armed) begin
          if (ticks != 32'hFFFF_FFFF) ticks = ticks + 32'd1;
          if (ticks >= timeout_limit) end_wait(OUT_TIMEOUT);
        end
      end
      OP_BYTE: begin
        if (armed) begin
          rx_count++;
          // drop every string the line no longer follows
          for (k = 0; k < NUM_PATTERNS; k++) begin
            if (int'(line_pos) >= reply_len(k) || reply_byte(k, int'(line_pos)) != data)
              alive[k] = 1'b0;
          end
          if (line_pos != POS_MAX) line_pos = line_pos + 4'd1;
          if (data == CHAR_NEWLINE) begin
            // first surviving string of exactly this length wins
            for (k = 0; k < NUM_PATTERNS; k++) begin
              if (!hit && alive[k] && int'(line_pos) == reply_len(k)) begin
                end_wait(OUT_OK + 3'(k));
                hit = 1'b1;
              end
            end
            if (!hit) begin
              line_pos = 4'd0;
              alive = 4'hF;
            end
          end
          // a match on the last byte beats buffer full
          if (!hit && rx_count >= BUFFER_BYTES_DEF - 1) end_wait(OUT_FULL);
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver: offers queued transactions with a random gap drawn per transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      operation <= OP_START;
      rx_byte <= 8'h00;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) advance_matcher(operation, rx_byte);
      // a stalled transaction holds; otherwise the slot is free
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (tx_items.size() > 0) begin
          head_xact = tx_items.pop_front();
          in_valid <= 1'b1;
          operation <= head_xact.op;
          rx_byte <= head_xact.data;
          send_wait = $urandom_range(0, send_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction against the oldest owed reply
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: outcome %0d bytes_seen %0d", outcome, bytes_seen);
          failures++;
        end else begin
          due = replies_due.pop_front();
          if (outcome !== due.code) begin
            $error("outcome: expected %0d, actual %0d", due.code, outcome);
            failures++;
          end
          if (bytes_seen !== due.count) begin
            $error("bytes_seen: expected %0d, actual %0d", due.count, bytes_seen);
            failures++;
          end
        end
        recv_wait = $urandom_range(0, recv_stall_max);
      end
      // long hold-off so the result register fills and the input backs up
      if (hold_served != hold_requests) begin
        hold_served++;
        recv_wait = HOLD_CYCLES;
      end
      if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic put(input logic [1:0] op, input logic [7:0] data);
    at_xact_t x;
    x.op = op;
    x.data = data;
    tx_items.push_back(x);
    staged++;
  endtask

  // a received byte, now and then preceded by a tick
  task automatic put_byte(input logic [7:0] b);
    if (tick_mix && $urandom_range(0, 9) == 0) put(OP_TICK, 8'($urandom));
    put(OP_BYTE, b);
  endtask

  // a reply string, optionally with one byte replaced
  task automatic put_reply(input int k, input int bad_pos, input logic [7:0] bad_byte);
    int pos;
    logic [7:0] b;
    for (pos = 0; pos < reply_len(k); pos++) begin
      b = reply_byte(k, pos);
      if (pos == bad_pos) b = bad_byte;
      put_byte(b);
    end
  endtask

  // bytes that never end a line
  task automatic put_filler(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == CHAR_NEWLINE) b = ~b;
      put(OP_BYTE, b);
    end
  endtask

  // one armed wait: a few lines, most sessions ending in an exact reply
  task automatic put_session();
    int kind;
    int k;
    int n;
    int pos;
    logic [1:0] op;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0:       op = OP_BYTE;
        1:       op = OP_TICK;
        default: op = OP_UNUSED;
      endcase
      put(op, 8'($urandom));
    end
    put(OP_START, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(0, 9);
      k = $urandom_range(0, NUM_PATTERNS - 1);
      case (kind)
        0, 1, 2, 3, 4: begin
          put_reply(k, -1, 8'h00);
          return;
        end
        5: put_reply(k, $urandom_range(0, reply_len(k) - 1), 8'($urandom));
        6: begin
          // cut short, then a bare newline
          n = $urandom_range(0, reply_len(k) - 1);
          for (pos = 0; pos < n; pos++) put_byte(reply_byte(k, pos));
          put_byte(CHAR_NEWLINE);
        end
        7: begin
          // one stray byte just ahead of the line ending
          for (pos = 0; pos < reply_len(k); pos++) begin
            if (pos == reply_len(k) - 2) put_byte(8'($urandom));
            put_byte(reply_byte(k, pos));
          end
        end
        8: begin
          // noise line, long enough at times to saturate the position
          repeat ($urandom_range(0, 18)) put_byte(8'($urandom));
          put_byte(CHAR_NEWLINE);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) put(OP_START, 8'($urandom));
          else put(OP_UNUSED, 8'($urandom));
        end
      endcase
    end
  endtask

  // wait until everything offered is accepted and every reply has come
  task automatic drain();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // input is drained here, so the shadow register may change with the block
  task automatic set_timeout(input logic [31:0] v);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    timeout_limit = v;
  endtask

  task automatic run_phase(input logic [31:0] limit, input int gap_max, input int stall_max,
                           input int n_items, input bit hold);
    int target;
    drain();
    set_timeout(limit);
    @(negedge clk);
    send_gap_max = gap_max;
    recv_stall_max = stall_max;
    tick_mix = 1'b1;
    if (hold) begin
      // with a zero timeout each start/tick pair owes a reply
      hold_requests++;
      repeat (16) begin
        put(OP_START, 8'($urandom));
        put(OP_TICK, 8'($urandom));
      end
    end
    target = staged + n_items;
    while (staged < target) put_session();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle transactions are ignored, timeout still at its reset value
    put(OP_BYTE, 8'hFF);
    put(OP_TICK, 8'h00);
    put(OP_UNUSED, 8'h00);
    put(OP_START, 8'h00);
    put_reply(0, -1, 8'h00);
    // re-armed mid line, then a line with a zero byte that must not match
    put(OP_START, 8'hFF);
    put(OP_BYTE, "E");
    put(OP_START, 8'h55);
    put(OP_BYTE, "O");
    put(OP_BYTE, 8'h00);
    put(OP_BYTE, 8'h0D);
    put(OP_BYTE, CHAR_NEWLINE);
    put_reply(0, -1, 8'h00);
    // zero timeout: the first tick ends the wait
    drain();
    set_timeout(32'd0);
    @(negedge clk);
    put(OP_START, 8'h00);
    put(OP_TICK, 8'h00);
    // timeout changed while armed takes effect on the next tick
    drain();
    set_timeout(32'hFFFF_FFFF);
    @(negedge clk);
    put(OP_START, 8'h00);
    put(OP_BYTE, "O");
    put(OP_TICK, 8'h00);
    drain();
    set_timeout(32'd1);
    @(negedge clk);
    put(OP_TICK, 8'hAA);

    // random sessions under a range of timeouts and idling mixes
    run_phase(32'd3, 8, 8, PHASE_ITEMS, 1'b0);
    run_phase(32'd0, 0, 0, PHASE_ITEMS, 1'b1);
    run_phase(32'd12, 8, 0, PHASE_ITEMS, 1'b0);
    run_phase(32'd1, 0, 8, PHASE_ITEMS, 1'b0);
    run_phase($urandom_range(5, 60), 8, 8, PHASE_ITEMS, 1'b0);
    run_phase(TIMEOUT_RESET, 3, 3, PHASE_ITEMS, 1'b0);
    run_phase(32'hFFFF_FFFF, 8, 8, PHASE_ITEMS, 1'b0);
    // buffer runs: first a reply landing on the last byte, then plain overflow
    put(OP_START, 8'($urandom));
    put_filler(BUFFER_BYTES_DEF - 6);
    put(OP_BYTE, CHAR_NEWLINE);
    put_reply(0, -1, 8'h00);
    put(OP_START, 8'($urandom));
    put_filler(BUFFER_BYTES_DEF - 1);
    run_phase($urandom, 8, 8, PHASE_ITEMS, 1'b0);

    drain();
    if (failures == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
